[design/nq_pkg.sv]
// shared types and constants for the n-queens solution search
// no dependencies; imported by nq_conflict and n_queens_solution_search
package nq_pkg;

  // board geometry
  localparam int QueenDepth = 16;
  localparam int ColW       = $clog2(QueenDepth);
  localparam int CntW       = ColW + 1;

  typedef logic [ColW-1:0] col_t;
  typedef logic [CntW-1:0] cnt_t;

  localparam cnt_t MAX_QUEENS = cnt_t'(QueenDepth);
  localparam cnt_t BOARD_RST  = cnt_t'(8);

  // search sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_BT_WAIT,
    ST_CHECK,
    ST_EMIT,
    ST_EXH
  } nq_state_e;

  // operands of the shared attack check
  typedef struct packed {
    col_t placed;
    col_t cand;
    cnt_t row_gap;
  } nq_chk_t;

endpackage

[design/nq_conflict.sv]
// shared attack check: same column or same diagonal as an earlier queen
// depends on nq_pkg
module nq_conflict (
  input  nq_pkg::nq_chk_t chk_i,
  output logic            hit_o
);
  import nq_pkg::*;

  col_t diff;

  // absolute column distance
  always_comb begin
    if (chk_i.placed > chk_i.cand) begin
      diff = chk_i.placed - chk_i.cand;
    end else begin
      diff = chk_i.cand - chk_i.placed;
    end
  end

  assign hit_o = (chk_i.placed == chk_i.cand) || ({1'b0, diff} == chk_i.row_gap);

endmodule

[design/n_queens_solution_search.sv]
// n-queens depth-first backtracking search, top level
// depends on nq_pkg and nq_conflict
//
// Usage: write board_size through cfg_we_i/cfg_wdata_i while the block is
// idle; a write clears the search so the next request starts afresh. Each
// input word (restart_i) asks for the next solution, or a fresh search when
// restart_i is high or no search has run. The block answers with one output
// word per row (row_index_o, column_index_o), last_row_o set on the final
// one, or a single word with exhausted_o and last_row_o set when no further
// solution exists. Sizes above 16 act as 16; size 0 gives exhausted at once.
// Timing: in_stall_o rises after acceptance and falls once the last output
// word is loaded. The search uses one shared attack checker: each candidate
// column is checked against the earlier rows one at a time, and a backtrack
// reads the previous row's column back from memory and resumes after it; a
// fitting column is written in its last check cycle (the first row needs no
// check), and a full board moves on to the emit state. Results then leave at
// one word per cycle through the output register while the output is not
// stalled. A stalled output word holds; while it waits, the emit and exhausted
// states pause. Reset sets board_size to 8 and clears the search; the column
// memory has no reset and is always written before read.
module n_queens_solution_search (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  nq_pkg::cnt_t         cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output nq_pkg::col_t         row_index_o,
  output nq_pkg::col_t         column_index_o,
  output logic                 last_row_o,
  output logic                 exhausted_o
);
  import nq_pkg::*;

  nq_state_e state_q, state_d;
  cnt_t      board_q;
  cnt_t      cursor_q, cursor_d;
  logic      started_q, started_d;
  logic      done_q, done_d;
  cnt_t      r_q, r_d;
  cnt_t      cand_q, cand_d;
  col_t      i_q, i_d;
  col_t      k_q, k_d;

  col_t      qcol_q [QueenDepth];
  col_t      rdata_q;
  col_t      raddr;
  logic      mem_we;

  logic      out_valid_q;
  col_t      row_q, col_q;
  logic      last_q, exh_q;
  logic      load_row, load_exh;

  cnt_t      n_eff;
  logic      in_acc, fresh, resume_bad, slot_free, hit;
  logic      last_k, check_end;
  nq_chk_t   chk;

  // effective board size
  assign n_eff = (board_q > MAX_QUEENS) ? MAX_QUEENS : board_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign fresh      = restart_i || !started_q;
  assign resume_bad = done_q || (cursor_q == '0) || (cursor_q > n_eff);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign last_k     = (({1'b0, k_q} + cnt_t'(1)) == n_eff);
  assign check_end  = (({1'b0, i_q} + cnt_t'(1)) == r_q);

  // shared attack check against the queen read from memory
  assign chk.placed  = rdata_q;
  assign chk.cand    = cand_q[ColW-1:0];
  assign chk.row_gap = r_q - {1'b0, i_q};

  nq_conflict u_conflict (
    .chk_i (chk),
    .hit_o (hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (fresh) begin
            state_d = (n_eff == '0) ? ST_EXH : ST_TOP;
          end else begin
            state_d = resume_bad ? ST_EXH : ST_BT_WAIT;
          end
        end
      end
      ST_TOP: begin
        if (r_q >= n_eff) begin
          state_d = ST_EMIT;
        end else if (cand_q >= n_eff) begin
          state_d = (r_q == '0) ? ST_EXH : ST_BT_WAIT;
        end else if (r_q != '0) begin
          state_d = ST_CHECK;
        end
      end
      ST_BT_WAIT: state_d = ST_TOP;
      ST_CHECK: begin
        if (hit || check_end) begin
          state_d = ST_TOP;
        end
      end
      ST_EMIT: begin
        if (slot_free && last_k) begin
          state_d = ST_IDLE;
        end
      end
      ST_EXH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath next values
  always_comb begin
    cursor_d  = cursor_q;
    started_d = started_q;
    done_d    = done_q;
    r_d       = r_q;
    cand_d    = cand_q;
    i_d       = i_q;
    k_d       = k_q;
    raddr     = i_q;
    mem_we    = 1'b0;
    load_row  = 1'b0;
    load_exh  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (fresh) begin
            started_d = 1'b1;
            done_d    = 1'b0;
            cursor_d  = '0;
            r_d       = '0;
            cand_d    = '0;
          end else if (!resume_bad) begin
            r_d   = cursor_q - cnt_t'(1);
            raddr = r_d[ColW-1:0];
          end
        end
      end
      ST_TOP: begin
        if (r_q >= n_eff) begin
          cursor_d = n_eff;
          k_d      = '0;
          raddr    = '0;
        end else if (cand_q >= n_eff) begin
          if (r_q == '0) begin
            cursor_d = '0;
          end else begin
            r_d   = r_q - cnt_t'(1);
            raddr = r_d[ColW-1:0];
          end
        end else if (r_q == '0) begin
          // first row needs no check
          mem_we = 1'b1;
          r_d    = cnt_t'(1);
          cand_d = '0;
        end else begin
          i_d   = '0;
          raddr = '0;
        end
      end
      ST_BT_WAIT: begin
        cand_d = {1'b0, rdata_q} + cnt_t'(1);
      end
      ST_CHECK: begin
        if (hit) begin
          cand_d = cand_q + cnt_t'(1);
        end else if (check_end) begin
          mem_we = 1'b1;
          r_d    = r_q + cnt_t'(1);
          cand_d = '0;
        end else begin
          i_d   = i_q + col_t'(1);
          raddr = i_d;
        end
      end
      ST_EMIT: begin
        raddr = k_q;
        if (slot_free) begin
          load_row = 1'b1;
          if (!last_k) begin
            k_d   = k_q + col_t'(1);
            raddr = k_d;
          end
        end
      end
      ST_EXH: begin
        if (slot_free) begin
          load_exh = 1'b1;
          done_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      board_q   <= BOARD_RST;
      cursor_q  <= '0;
      started_q <= 1'b0;
      done_q    <= 1'b0;
      r_q       <= '0;
      cand_q    <= '0;
      i_q       <= '0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      cand_q  <= cand_d;
      i_q     <= i_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        board_q   <= cfg_wdata_i;
        cursor_q  <= '0;
        started_q <= 1'b0;
        done_q    <= 1'b0;
      end else begin
        cursor_q  <= cursor_d;
        started_q <= started_d;
        done_q    <= done_d;
      end
    end
  end

  // column memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      qcol_q[r_q[ColW-1:0]] <= cand_q[ColW-1:0];
    end
    rdata_q <= qcol_q[raddr];
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_row || load_exh) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_row) begin
      row_q  <= k_q;
      col_q  <= rdata_q;
      last_q <= last_k;
      exh_q  <= 1'b0;
    end else if (load_exh) begin
      row_q  <= '0;
      col_q  <= '0;
      last_q <= 1'b1;
      exh_q  <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_index_o    = row_q;
  assign column_index_o = col_q;
  assign last_row_o     = last_q;
  assign exhausted_o    = exh_q;

  // checks on the sequencer and the output word
  a_check_below_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> ({1'b0, i_q} < r_q))
    else $error("check index not below current row");

  a_top_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TOP) |-> (r_q <= n_eff))
    else $error("row cursor beyond board size");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> ({1'b0, k_q} < n_eff))
    else $error("emit row beyond board size");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted word left sequencer idle");

  a_exh_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && exh_q) |-> (last_q && (row_q == '0) && (col_q == '0)))
    else $error("malformed exhausted word");

endmodule
